### rtl/cap_pkg.sv
// Package for the complex arithmetic unit with polar conversion.
// Holds operation and status codes, default widths and the CORDIC angle table.
// No dependencies.
package cap_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 8;

   // angle accumulator: degrees scaled by 2^ANG_BITS
   localparam int ANG_BITS     = 16;
   localparam int ANG_W        = 27;
   localparam int CORDIC_STEPS = 23;

   localparam logic [2:0] CMD_PASS = 3'd0;
   localparam logic [2:0] CMD_ADD  = 3'd1;
   localparam logic [2:0] CMD_SUB  = 3'd2;
   localparam logic [2:0] CMD_MUL  = 3'd3;
   localparam logic [2:0] CMD_DIV  = 3'd4;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_SAT = 2'd1;
   localparam logic [1:0] ST_DZ  = 2'd2;

   // arctan(2^-i) in degrees, scaled by 2^ANG_BITS, rounded
   function automatic logic signed [ANG_W-1:0] atan_deg(input int i);
      logic signed [ANG_W-1:0] v;
      case (i)
         0:  v = ANG_W'(2949120);
         1:  v = ANG_W'(1740967);
         2:  v = ANG_W'(919879);
         3:  v = ANG_W'(466945);
         4:  v = ANG_W'(234379);
         5:  v = ANG_W'(117304);
         6:  v = ANG_W'(58666);
         7:  v = ANG_W'(29335);
         8:  v = ANG_W'(14668);
         9:  v = ANG_W'(7334);
         10: v = ANG_W'(3667);
         11: v = ANG_W'(1833);
         12: v = ANG_W'(917);
         13: v = ANG_W'(458);
         14: v = ANG_W'(229);
         15: v = ANG_W'(115);
         16: v = ANG_W'(57);
         17: v = ANG_W'(29);
         18: v = ANG_W'(14);
         19: v = ANG_W'(7);
         20: v = ANG_W'(4);
         21: v = ANG_W'(2);
         22: v = ANG_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### rtl/cap_if.sv
// Valid/ready channel interfaces for the request and response streams.
// Depends on nothing; widths follow the DATA_WIDTH parameter.
interface cap_req_if #(parameter int DATA_WIDTH = 16) ();
   logic                         valid;
   logic                         ready;
   logic [2:0]                   cmd;
   logic signed [DATA_WIDTH-1:0] a_re;
   logic signed [DATA_WIDTH-1:0] a_im;
   logic signed [DATA_WIDTH-1:0] b_re;
   logic signed [DATA_WIDTH-1:0] b_im;

   modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cap_rsp_if #(parameter int DATA_WIDTH = 16) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] res_re;
   logic signed [DATA_WIDTH-1:0] res_im;
   logic [DATA_WIDTH-1:0]        magnitude;
   logic signed [DATA_WIDTH:0]   angle_deg;
   logic [1:0]                   status;

   modport source (output valid, res_re, res_im, magnitude, angle_deg, status, input ready);
   modport sink   (input valid, res_re, res_im, magnitude, angle_deg, status, output ready);
endinterface

### rtl/cap_divider.sv
// Pipelined restoring divider, two quotients sharing one divisor.
// Forms round(n * 2^F / d) as (2n*2^F + d) / 2d, one quotient bit per stage.
// No package dependencies.
module cap_divider #(
   parameter int W     = 16,
   parameter int F     = 8,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [2*W-1:0]   in_num_re,
   input  logic [2*W-1:0]   in_num_im,
   input  logic [2*W-1:0]   in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [W:0]       out_q_re,
   output logic [W:0]       out_q_im,
   output logic             out_ovf_re,
   output logic             out_ovf_im,
   output logic [TAG_W-1:0] out_tag
);
   localparam int Q  = W + 1;
   localparam int CW = 3 * W + F + 3;

   logic             valid_ff [0:Q];
   logic [CW-1:0]    r_re_ff  [0:Q];
   logic [CW-1:0]    r_im_ff  [0:Q];
   logic [Q-1:0]     q_re_ff  [0:Q];
   logic [Q-1:0]     q_im_ff  [0:Q];
   logic [CW-1:0]    v_ff     [0:Q];
   logic             ovf_re_ff [0:Q];
   logic             ovf_im_ff [0:Q];
   logic [TAG_W-1:0] tag_ff   [0:Q];

   logic [CW-1:0] d_re_in, d_im_in, v_in, lim;

   assign d_re_in = (CW'(in_num_re) << (F + 1)) + CW'(in_den);
   assign d_im_in = (CW'(in_num_im) << (F + 1)) + CW'(in_den);
   assign v_in    = CW'(in_den) << 1;
   assign lim     = v_in << Q;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         r_re_ff[0]   <= d_re_in;
         r_im_ff[0]   <= d_im_in;
         q_re_ff[0]   <= '0;
         q_im_ff[0]   <= '0;
         v_ff[0]      <= v_in;
         ovf_re_ff[0] <= d_re_in >= lim;
         ovf_im_ff[0] <= d_im_in >= lim;
         tag_ff[0]    <= in_tag;
      end
   end

   for (genvar k = 1; k <= Q; k++) begin : g_stage
      localparam int B = Q - k;
      logic [CW-1:0] trial;
      logic          ge_re, ge_im;

      assign trial = v_ff[k-1] << B;
      assign ge_re = r_re_ff[k-1] >= trial;
      assign ge_im = r_im_ff[k-1] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (en) begin
            r_re_ff[k]   <= ge_re ? r_re_ff[k-1] - trial : r_re_ff[k-1];
            r_im_ff[k]   <= ge_im ? r_im_ff[k-1] - trial : r_im_ff[k-1];
            q_re_ff[k]   <= q_re_ff[k-1] | (Q'(ge_re) << B);
            q_im_ff[k]   <= q_im_ff[k-1] | (Q'(ge_im) << B);
            v_ff[k]      <= v_ff[k-1];
            ovf_re_ff[k] <= ovf_re_ff[k-1];
            ovf_im_ff[k] <= ovf_im_ff[k-1];
            tag_ff[k]    <= tag_ff[k-1];
         end
      end
   end

   assign out_valid  = valid_ff[Q];
   assign out_q_re   = q_re_ff[Q];
   assign out_q_im   = q_im_ff[Q];
   assign out_ovf_re = ovf_re_ff[Q];
   assign out_ovf_im = ovf_im_ff[Q];
   assign out_tag    = tag_ff[Q];

endmodule

### rtl/cap_polar.sv
// Rectangular to polar pipeline: bit-per-stage square root with round to nearest
// and a vectoring CORDIC for the angle in degrees, running side by side.
// Depends on cap_pkg for the angle table and accumulator widths.
module cap_polar #(
   parameter int W     = 16,
   parameter int F     = 8,
   parameter int TAG_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [W-1:0] in_re,
   input  logic signed [W-1:0] in_im,
   input  logic [TAG_W-1:0]    in_tag,
   output logic                out_valid,
   output logic [W-1:0]        out_mag,
   output logic signed [W:0]   out_ang,
   output logic [TAG_W-1:0]    out_tag
);
   localparam int AB    = cap_pkg::ANG_BITS;
   localparam int ZW    = cap_pkg::ANG_W;
   localparam int STEPS = cap_pkg::CORDIC_STEPS;
   localparam int XW    = W + AB + 3;
   localparam int RW    = 2 * W + 1;
   localparam int N     = (W > STEPS) ? W : STEPS;
   localparam int SH    = AB - F;

   localparam logic signed [ZW-1:0] FULL = ZW'(180) <<< F;
   localparam logic signed [ZW-1:0] HALF = ZW'(90) <<< F;
   localparam logic signed [ZW-1:0] Z180 = ZW'(180) <<< AB;
   localparam logic signed [ZW-1:0] ZRND = ZW'(1) <<< (SH - 1);

   logic                valid_ff [0:N];
   logic [RW-1:0]       rem_ff   [0:N];
   logic [W-1:0]        root_ff  [0:N];
   logic signed [XW-1:0] x_ff    [0:N];
   logic signed [XW-1:0] y_ff    [0:N];
   logic signed [ZW-1:0] z_ff    [0:N];
   logic                axis_ff  [0:N];
   logic signed [ZW-1:0] aang_ff [0:N];
   logic [TAG_W-1:0]    tag_ff   [0:N];

   logic signed [2*W-1:0] sq_re, sq_im;
   logic [RW-1:0]         sq_in;
   logic signed [XW-1:0]  xs, ys, x_in, y_in;
   logic signed [ZW-1:0]  z_in, aang_in;
   logic                  axis_in;

   always_comb begin
      sq_re   = in_re * in_re;
      sq_im   = in_im * in_im;
      sq_in   = RW'(unsigned'(sq_re)) + RW'(unsigned'(sq_im));
      xs      = XW'(in_re) <<< AB;
      ys      = XW'(in_im) <<< AB;
      axis_in = (in_re == '0) || (in_im == '0);
      if (in_im == '0) begin
         aang_in = in_re[W-1] ? FULL : '0;
      end else begin
         aang_in = (in_im > 0) ? HALF : -HALF;
      end
      if (in_re[W-1]) begin
         x_in = -xs;
         y_in = -ys;
         z_in = (in_im > 0) ? Z180 : -Z180;
      end else begin
         x_in = xs;
         y_in = ys;
         z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0]  <= sq_in;
         root_ff[0] <= '0;
         x_ff[0]    <= x_in;
         y_ff[0]    <= y_in;
         z_ff[0]    <= z_in;
         axis_ff[0] <= axis_in;
         aang_ff[0] <= aang_in;
         tag_ff[0]  <= in_tag;
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_stage
      logic [RW-1:0]        rem_in;
      logic [W-1:0]         root_in;
      logic signed [XW-1:0] xn, yn;
      logic signed [ZW-1:0] zn;

      if (k <= W) begin : g_sqrt
         localparam int B = W - k;
         logic [RW-1:0] trial;
         assign trial   = (RW'(root_ff[k-1]) << (B + 1)) + (RW'(1) << (2 * B));
         assign rem_in  = (rem_ff[k-1] >= trial) ? rem_ff[k-1] - trial : rem_ff[k-1];
         assign root_in = root_ff[k-1] | (W'(rem_ff[k-1] >= trial) << B);
      end else begin : g_sqrt_hold
         assign rem_in  = rem_ff[k-1];
         assign root_in = root_ff[k-1];
      end

      if (k <= STEPS) begin : g_cordic
         localparam int I = k - 1;
         logic signed [XW-1:0] dx, dy;
         assign dx = y_ff[k-1] >>> I;
         assign dy = x_ff[k-1] >>> I;
         assign xn = y_ff[k-1][XW-1] ? x_ff[k-1] - dx : x_ff[k-1] + dx;
         assign yn = y_ff[k-1][XW-1] ? y_ff[k-1] + dy : y_ff[k-1] - dy;
         assign zn = y_ff[k-1][XW-1] ? z_ff[k-1] - cap_pkg::atan_deg(I)
                                     : z_ff[k-1] + cap_pkg::atan_deg(I);
      end else begin : g_cordic_hold
         assign xn = x_ff[k-1];
         assign yn = y_ff[k-1];
         assign zn = z_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            x_ff[k]    <= xn;
            y_ff[k]    <= yn;
            z_ff[k]    <= zn;
            axis_ff[k] <= axis_ff[k-1];
            aang_ff[k] <= aang_ff[k-1];
            tag_ff[k]  <= tag_ff[k-1];
         end
      end
   end

   // final rounding of both results
   logic [W:0]           mag_w;
   logic signed [ZW-1:0] zr, ang_sel;

   always_comb begin
      mag_w = (W + 1)'(root_ff[N]) + (W + 1)'(rem_ff[N] > RW'(root_ff[N]));
      zr    = (z_ff[N] + ZRND) >>> SH;
      if (axis_ff[N]) begin
         ang_sel = aang_ff[N];
      end else if (zr > FULL) begin
         ang_sel = FULL;
      end else if (zr < -FULL) begin
         ang_sel = -FULL;
      end else begin
         ang_sel = zr;
      end
   end

   logic                valid_out_ff;
   logic [W-1:0]        mag_ff;
   logic signed [W:0]   ang_ff;
   logic [TAG_W-1:0]    tag_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_out_ff <= 1'b0;
      end else if (en) begin
         valid_out_ff <= valid_ff[N];
      end
      if (en) begin
         mag_ff     <= mag_w[W-1:0];
         ang_ff     <= ang_sel[W:0];
         tag_out_ff <= tag_ff[N];
      end
   end

   assign out_valid = valid_out_ff;
   assign out_mag   = mag_ff;
   assign out_ang   = ang_ff;
   assign out_tag   = tag_out_ff;

endmodule

### rtl/complex_arith_polar_unit.sv
// Complex arithmetic unit with polar conversion: top level.
// Depends on cap_pkg, cap_if, cap_divider and cap_polar.
//
// One transfer in, one transfer out, in order. The unit is a single pipeline that takes a
// new operand pair every cycle unless it is held; its depth is set by the one-bit-per-stage
// divider followed by the 23-step angle CORDIC that runs beside the square root. Every
// operation takes the same path and the same latency. When the result is not taken, the
// whole pipeline holds.
module complex_arith_polar_unit #(
   parameter int DATA_WIDTH = cap_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cap_pkg::FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   cap_req_if.sink   req_if,
   cap_rsp_if.source rsp_if
);
   localparam int W      = DATA_WIDTH;
   localparam int F      = FRAC_BITS;
   localparam int PW     = 2 * W;
   localparam int DTAG_W = 2 * W + 5;
   localparam int PTAG_W = 2 * W + 2;

   localparam logic signed [PW+1:0] HI_W = {{(PW - W + 3){1'b0}}, {(W - 1){1'b1}}};
   localparam logic signed [PW+1:0] LO_W = ~HI_W;
   localparam logic signed [PW+1:0] RND  =
      (F > 0) ? ((PW + 2)'(1) <<< ((F > 0) ? F - 1 : 0)) : '0;
   localparam logic [W-1:0] HI_D = HI_W[W-1:0];
   localparam logic [W-1:0] LO_D = LO_W[W-1:0];
   localparam logic [W:0]   NEG_LIM = (W + 1)'(1) << (W - 1);
   localparam logic [W:0]   POS_LIM = NEG_LIM - 1'b1;

   logic en;
   assign en           = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = en;

   // stage 1: products and sums
   logic                 s1_valid_ff;
   logic [2:0]           s1_cmd_ff;
   logic signed [W:0]    s1_re_ff, s1_im_ff, s1_re_in, s1_im_in;
   logic signed [PW-1:0] s1_prr_ff, s1_pii_ff, s1_pir_ff, s1_pri_ff, s1_pbb_ff, s1_pqq_ff;

   always_comb begin
      unique case (req_if.cmd)
         cap_pkg::CMD_ADD: begin
            s1_re_in = (W + 1)'(req_if.a_re) + (W + 1)'(req_if.b_re);
            s1_im_in = (W + 1)'(req_if.a_im) + (W + 1)'(req_if.b_im);
         end
         cap_pkg::CMD_SUB: begin
            s1_re_in = (W + 1)'(req_if.a_re) - (W + 1)'(req_if.b_re);
            s1_im_in = (W + 1)'(req_if.a_im) - (W + 1)'(req_if.b_im);
         end
         default: begin
            s1_re_in = (W + 1)'(req_if.a_re);
            s1_im_in = (W + 1)'(req_if.a_im);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_if.valid;
      end
      if (en) begin
         s1_cmd_ff <= req_if.cmd;
         s1_re_ff  <= s1_re_in;
         s1_im_ff  <= s1_im_in;
         s1_prr_ff <= req_if.a_re * req_if.b_re;
         s1_pii_ff <= req_if.a_im * req_if.b_im;
         s1_pir_ff <= req_if.a_im * req_if.b_re;
         s1_pri_ff <= req_if.a_re * req_if.b_im;
         s1_pbb_ff <= req_if.b_re * req_if.b_re;
         s1_pqq_ff <= req_if.b_im * req_if.b_im;
      end
   end

   // stage 2: multiply rounding, saturation, divider operands
   logic signed [PW+1:0] mul_re_w, mul_im_w, nd_re_w, nd_im_w;
   logic signed [PW:0]   n_re, n_im;
   logic [PW:0]          den_w;
   logic                 is_mul, sat_re, sat_im;
   logic [W-1:0]         nd_re_in, nd_im_in;

   always_comb begin
      is_mul   = s1_cmd_ff == cap_pkg::CMD_MUL;
      mul_re_w = ((PW + 2)'(s1_prr_ff) - (PW + 2)'(s1_pii_ff) + RND) >>> F;
      mul_im_w = ((PW + 2)'(s1_pir_ff) + (PW + 2)'(s1_pri_ff) + RND) >>> F;
      nd_re_w  = is_mul ? mul_re_w : (PW + 2)'(s1_re_ff);
      nd_im_w  = is_mul ? mul_im_w : (PW + 2)'(s1_im_ff);
      sat_re   = (nd_re_w > HI_W) || (nd_re_w < LO_W);
      sat_im   = (nd_im_w > HI_W) || (nd_im_w < LO_W);
      nd_re_in = sat_re ? (nd_re_w[PW+1] ? LO_D : HI_D) : nd_re_w[W-1:0];
      nd_im_in = sat_im ? (nd_im_w[PW+1] ? LO_D : HI_D) : nd_im_w[W-1:0];
      n_re     = (PW + 1)'(s1_prr_ff) + (PW + 1)'(s1_pii_ff);
      n_im     = (PW + 1)'(s1_pir_ff) - (PW + 1)'(s1_pri_ff);
      den_w    = (PW + 1)'(unsigned'(s1_pbb_ff)) + (PW + 1)'(unsigned'(s1_pqq_ff));
   end

   logic          s2_valid_ff, s2_div_ff, s2_dz_ff, s2_sat_ff, s2_neg_re_ff, s2_neg_im_ff;
   logic [W-1:0]  s2_re_ff, s2_im_ff;
   logic [PW-1:0] s2_num_re_ff, s2_num_im_ff, s2_den_ff;
   logic [PW:0]   abs_re, abs_im;

   assign abs_re = n_re[PW] ? -n_re : n_re;
   assign abs_im = n_im[PW] ? -n_im : n_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_div_ff    <= s1_cmd_ff == cap_pkg::CMD_DIV;
         s2_dz_ff     <= den_w == '0;
         s2_sat_ff    <= sat_re || sat_im;
         s2_re_ff     <= nd_re_in;
         s2_im_ff     <= nd_im_in;
         s2_neg_re_ff <= n_re[PW];
         s2_neg_im_ff <= n_im[PW];
         s2_num_re_ff <= abs_re[PW-1:0];
         s2_num_im_ff <= abs_im[PW-1:0];
         s2_den_ff    <= den_w[PW-1:0];
      end
   end

   // divider
   logic              d_valid, d_ovf_re, d_ovf_im;
   logic [W:0]        d_q_re, d_q_im;
   logic [DTAG_W-1:0] d_tag_in, d_tag;

   assign d_tag_in = {s2_div_ff, s2_dz_ff, s2_sat_ff, s2_re_ff, s2_im_ff,
                      s2_neg_re_ff, s2_neg_im_ff};

   cap_divider #(
      .W     (W),
      .F     (F),
      .TAG_W (DTAG_W)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (s2_valid_ff),
      .in_num_re  (s2_num_re_ff),
      .in_num_im  (s2_num_im_ff),
      .in_den     (s2_den_ff),
      .in_tag     (d_tag_in),
      .out_valid  (d_valid),
      .out_q_re   (d_q_re),
      .out_q_im   (d_q_im),
      .out_ovf_re (d_ovf_re),
      .out_ovf_im (d_ovf_im),
      .out_tag    (d_tag)
   );

   // merge: quotient saturation and status
   logic         t_div, t_dz, t_sat, t_neg_re, t_neg_im, dsat_re, dsat_im;
   logic [W-1:0] t_re, t_im, dre, dim, m_re_in, m_im_in;
   logic [W:0]   qn_re, qn_im;
   logic [1:0]   m_status_in;

   always_comb begin
      {t_div, t_dz, t_sat, t_re, t_im, t_neg_re, t_neg_im} = d_tag;
      qn_re   = -d_q_re;
      qn_im   = -d_q_im;
      dsat_re = d_ovf_re || (t_neg_re ? d_q_re > NEG_LIM : d_q_re > POS_LIM);
      dsat_im = d_ovf_im || (t_neg_im ? d_q_im > NEG_LIM : d_q_im > POS_LIM);
      dre     = dsat_re ? (t_neg_re ? LO_D : HI_D) : (t_neg_re ? qn_re[W-1:0] : d_q_re[W-1:0]);
      dim     = dsat_im ? (t_neg_im ? LO_D : HI_D) : (t_neg_im ? qn_im[W-1:0] : d_q_im[W-1:0]);
      if (t_div && t_dz) begin
         m_re_in     = '0;
         m_im_in     = '0;
         m_status_in = cap_pkg::ST_DZ;
      end else if (t_div) begin
         m_re_in     = dre;
         m_im_in     = dim;
         m_status_in = (dsat_re || dsat_im) ? cap_pkg::ST_SAT : cap_pkg::ST_OK;
      end else begin
         m_re_in     = t_re;
         m_im_in     = t_im;
         m_status_in = t_sat ? cap_pkg::ST_SAT : cap_pkg::ST_OK;
      end
   end

   logic         m_valid_ff;
   logic [W-1:0] m_re_ff, m_im_ff;
   logic [1:0]   m_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= d_valid;
      end
      if (en) begin
         m_re_ff     <= m_re_in;
         m_im_ff     <= m_im_in;
         m_status_ff <= m_status_in;
      end
   end

   // polar form
   logic [PTAG_W-1:0] p_tag;

   cap_polar #(
      .W     (W),
      .F     (F),
      .TAG_W (PTAG_W)
   ) u_polar (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m_valid_ff),
      .in_re     (signed'(m_re_ff)),
      .in_im     (signed'(m_im_ff)),
      .in_tag    ({m_re_ff, m_im_ff, m_status_ff}),
      .out_valid (rsp_if.valid),
      .out_mag   (rsp_if.magnitude),
      .out_ang   (rsp_if.angle_deg),
      .out_tag   (p_tag)
   );

   assign rsp_if.res_re = signed'(p_tag[PTAG_W-1 -: W]);
   assign rsp_if.res_im = signed'(p_tag[W+1:2]);
   assign rsp_if.status = p_tag[1:0];

endmodule
